// File: src/randomized_dfs_maze_carver_unit_defines.svh
// ----------------------------------------------------------------------------
// Maze carver assertion macros
// Concurrent check wrappers, empty when synthesized.
// ----------------------------------------------------------------------------
`ifndef RANDOMIZED_DFS_MAZE_CARVER_UNIT_DEFINES_SVH
`define RANDOMIZED_DFS_MAZE_CARVER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define RDMC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define RDMC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RDMC_ASSERT(lbl, clk, rst_n, prop, msg)
`define RDMC_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// File: src/rdmc_pkg.sv
// ----------------------------------------------------------------------------
// Maze carver package
// Item types, state encoding, directions and the shuffle helper.
// ----------------------------------------------------------------------------
package rdmc_pkg;

    localparam int GRID_SIZE_DEF = 64;
    localparam int OUT_W = 6;

    typedef logic [1:0] t_dir;
    typedef logic [3:0][1:0] t_order;

    localparam t_dir DIR_COL_INC = 2'd0;
    localparam t_dir DIR_ROW_INC = 2'd1;
    localparam t_dir DIR_COL_DEC = 2'd2;
    localparam t_dir DIR_ROW_DEC = 2'd3;

    typedef struct packed {
        logic [1:0] pick_of_four;
        logic [1:0] pick_of_three;
        logic       pick_of_two;
    } t_in_item;

    typedef struct packed {
        logic [OUT_W-1:0] wall_row;
        logic [OUT_W-1:0] wall_col;
        logic [OUT_W-1:0] node_row;
        logic [OUT_W-1:0] node_col;
        logic             walk_done;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOAD,
        ST_SCAN,
        ST_TEST,
        ST_EMIT
    } t_state;

    function automatic t_order shuffle_order(input t_in_item item);
        t_order     ord;
        logic [1:0] p3;
        t_dir       tmp;
        ord = {DIR_ROW_DEC, DIR_COL_DEC, DIR_ROW_INC, DIR_COL_INC};
        p3  = (item.pick_of_three == 2'd3) ? 2'd2 : item.pick_of_three;
        tmp = ord[3];
        ord[3] = ord[item.pick_of_four];
        ord[item.pick_of_four] = tmp;
        tmp = ord[2];
        ord[2] = ord[p3];
        ord[p3] = tmp;
        tmp = ord[1];
        ord[1] = ord[{1'b0, item.pick_of_two}];
        ord[{1'b0, item.pick_of_two}] = tmp;
        return ord;
    endfunction

endpackage

// File: src/randomized_dfs_maze_carver_unit.sv
// ----------------------------------------------------------------------------
// Randomized depth-first maze carver
// Recursive backtracker with visited map and walk stack in block memories.
// ----------------------------------------------------------------------------
// Each input item carries the three shuffle picks for the pending node; the
// block answers with one result item: the wall cell carved and the next node,
// or walk_done when the stack has emptied (the walk then restarts at (1,1)).
// An item occupies the block until its result is formed: a direction leading
// off the grid is skipped in ST_SCAN, one on the grid is checked against the
// visited map in ST_TEST and a stack entry popped while backtracking is read
// back in ST_LOAD, as each memory has a single read port. After reset a
// clearing pass over all ((GRID_SIZE-1)/2)^2 entries (961 at the default size)
// zeroes the visited map before the first item is taken. A finished result
// waits in an output register while the next item is accepted; the result
// after it is held back until that register is free.
module randomized_dfs_maze_carver_unit
    import rdmc_pkg::*;
#(
    parameter int GRID_SIZE = GRID_SIZE_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

`include "randomized_dfs_maze_carver_unit_defines.svh"

    localparam int SPAN       = (GRID_SIZE - 1) / 2;
    localparam int NODE_COUNT = SPAN * SPAN;
    localparam int IDX_W      = $clog2(SPAN);
    localparam int SLOT_W     = $clog2(NODE_COUNT);
    localparam int DEPTH_W    = $clog2(NODE_COUNT + 1);
    localparam int COORD_W    = IDX_W + 1;
    localparam int FRAME_W    = 2 * IDX_W + 8 + 3;

    t_state             r_state, n_state;
    logic [SLOT_W-1:0]  r_clr_cnt, n_clr_cnt;
    logic [DEPTH_W-1:0] r_depth, n_depth;
    logic [IDX_W-1:0]   r_pend_row, n_pend_row;
    logic [IDX_W-1:0]   r_pend_col, n_pend_col;
    logic [IDX_W-1:0]   r_row, n_row;
    logic [IDX_W-1:0]   r_col, n_col;
    t_order             r_ord, n_ord;
    logic [2:0]         r_next, n_next;
    logic [IDX_W-1:0]   r_nb_row, n_nb_row;
    logic [IDX_W-1:0]   r_nb_col, n_nb_col;
    logic [COORD_W-1:0] r_wall_row, n_wall_row;
    logic [COORD_W-1:0] r_wall_col, n_wall_col;
    t_out_item          r_res, n_res;
    logic               r_out_valid, n_out_valid;
    t_out_item          r_out_item, n_out_item;

    logic               vis_mem [NODE_COUNT];
    logic               vis_we, vis_wdata;
    logic [SLOT_W-1:0]  vis_waddr, vis_raddr;
    logic               r_vis_rd;

    logic [FRAME_W-1:0] stk_mem [NODE_COUNT];
    logic               stk_we;
    logic [FRAME_W-1:0] stk_wdata;
    logic [SLOT_W-1:0]  stk_waddr, stk_raddr;
    logic [FRAME_W-1:0] r_stk_rd;

    t_order             new_ord;
    t_dir               dir;
    logic               nb_ok;
    logic [IDX_W-1:0]   nb_row, nb_col;
    logic [COORD_W-1:0] row_coord, col_coord, wr_coord, wc_coord;
    logic [DEPTH_W-1:0] depth_m1, depth_m2;
    logic [COORD_W+OUT_W-1:0] wr_ext, wc_ext, nr_ext, nc_ext;

    assign new_ord   = shuffle_order(i_in_item);
    assign dir       = r_ord[r_next[1:0]];
    assign row_coord = {r_row, 1'b1};
    assign col_coord = {r_col, 1'b1};
    assign depth_m1  = r_depth - DEPTH_W'(1);
    assign depth_m2  = r_depth - DEPTH_W'(2);
    assign wr_ext    = {{OUT_W{1'b0}}, r_wall_row};
    assign wc_ext    = {{OUT_W{1'b0}}, r_wall_col};
    assign nr_ext    = {{OUT_W{1'b0}}, r_nb_row, 1'b1};
    assign nc_ext    = {{OUT_W{1'b0}}, r_nb_col, 1'b1};

    always_comb begin
        nb_ok    = 1'b0;
        nb_row   = r_row;
        nb_col   = r_col;
        wr_coord = row_coord;
        wc_coord = col_coord;
        case (dir)
            DIR_COL_INC: begin
                nb_ok    = (r_col != IDX_W'(SPAN - 1));
                nb_col   = r_col + IDX_W'(1);
                wc_coord = col_coord + COORD_W'(1);
            end
            DIR_ROW_INC: begin
                nb_ok    = (r_row != IDX_W'(SPAN - 1));
                nb_row   = r_row + IDX_W'(1);
                wr_coord = row_coord + COORD_W'(1);
            end
            DIR_COL_DEC: begin
                nb_ok    = (r_col != '0);
                nb_col   = r_col - IDX_W'(1);
                wc_coord = col_coord - COORD_W'(1);
            end
            DIR_ROW_DEC: begin
                nb_ok    = (r_row != '0);
                nb_row   = r_row - IDX_W'(1);
                wr_coord = row_coord - COORD_W'(1);
            end
            default: begin
                nb_ok = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_clr_cnt   = r_clr_cnt;
        n_depth     = r_depth;
        n_pend_row  = r_pend_row;
        n_pend_col  = r_pend_col;
        n_row       = r_row;
        n_col       = r_col;
        n_ord       = r_ord;
        n_next      = r_next;
        n_nb_row    = r_nb_row;
        n_nb_col    = r_nb_col;
        n_wall_row  = r_wall_row;
        n_wall_col  = r_wall_col;
        n_res       = r_res;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_item  = r_out_item;
        vis_we      = 1'b0;
        vis_wdata   = 1'b0;
        vis_waddr   = '0;
        vis_raddr   = '0;
        stk_we      = 1'b0;
        stk_wdata   = '0;
        stk_waddr   = '0;
        stk_raddr   = '0;
        o_in_ready  = 1'b0;

        case (r_state)
            ST_CLEAR: begin
                vis_we    = 1'b1;
                vis_waddr = r_clr_cnt;
                n_clr_cnt = r_clr_cnt + SLOT_W'(1);
                if (r_clr_cnt == SLOT_W'(NODE_COUNT - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    vis_we    = 1'b1;
                    vis_wdata = 1'b1;
                    vis_waddr = SLOT_W'(r_pend_row) * SLOT_W'(SPAN) + SLOT_W'(r_pend_col);
                    if (r_depth < DEPTH_W'(NODE_COUNT)) begin
                        stk_we    = 1'b1;
                        stk_waddr = r_depth[SLOT_W-1:0];
                        stk_wdata = {r_pend_row, r_pend_col, new_ord, 3'd0};
                        n_row     = r_pend_row;
                        n_col     = r_pend_col;
                        n_ord     = new_ord;
                        n_next    = 3'd0;
                        n_depth   = r_depth + DEPTH_W'(1);
                        n_state   = ST_SCAN;
                    end else begin
                        stk_raddr = depth_m1[SLOT_W-1:0];
                        n_state   = ST_LOAD;
                    end
                end
            end
            ST_LOAD: begin
                {n_row, n_col, n_ord, n_next} = r_stk_rd;
                n_state = ST_SCAN;
            end
            ST_SCAN: begin
                if (r_next[2]) begin
                    n_depth = depth_m1;
                    if (depth_m1 == '0) begin
                        n_res      = '0;
                        n_res.walk_done = 1'b1;
                        n_pend_row = '0;
                        n_pend_col = '0;
                        n_state    = ST_EMIT;
                    end else begin
                        stk_raddr = depth_m2[SLOT_W-1:0];
                        n_state   = ST_LOAD;
                    end
                end else begin
                    n_next = r_next + 3'd1;
                    if (nb_ok) begin
                        vis_raddr  = SLOT_W'(nb_row) * SLOT_W'(SPAN) + SLOT_W'(nb_col);
                        n_nb_row   = nb_row;
                        n_nb_col   = nb_col;
                        n_wall_row = wr_coord;
                        n_wall_col = wc_coord;
                        n_state    = ST_TEST;
                    end
                end
            end
            ST_TEST: begin
                if (!r_vis_rd) begin
                    stk_we     = 1'b1;
                    stk_waddr  = depth_m1[SLOT_W-1:0];
                    stk_wdata  = {r_row, r_col, r_ord, r_next};
                    n_pend_row = r_nb_row;
                    n_pend_col = r_nb_col;
                    n_res.wall_row  = wr_ext[OUT_W-1:0];
                    n_res.wall_col  = wc_ext[OUT_W-1:0];
                    n_res.node_row  = nr_ext[OUT_W-1:0];
                    n_res.node_col  = nc_ext[OUT_W-1:0];
                    n_res.walk_done = 1'b0;
                    n_state    = ST_EMIT;
                end else begin
                    n_state = ST_SCAN;
                end
            end
            ST_EMIT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_out_item  = r_res;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_cnt   <= '0;
            r_depth     <= '0;
            r_pend_row  <= '0;
            r_pend_col  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_cnt   <= n_clr_cnt;
            r_depth     <= n_depth;
            r_pend_row  <= n_pend_row;
            r_pend_col  <= n_pend_col;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_row      <= n_row;
        r_col      <= n_col;
        r_ord      <= n_ord;
        r_next     <= n_next;
        r_nb_row   <= n_nb_row;
        r_nb_col   <= n_nb_col;
        r_wall_row <= n_wall_row;
        r_wall_col <= n_wall_col;
        r_res      <= n_res;
        r_out_item <= n_out_item;
    end

    always_ff @(posedge i_clk) begin
        if (vis_we) begin
            vis_mem[vis_waddr] <= vis_wdata;
        end
        r_vis_rd <= vis_mem[vis_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (stk_we) begin
            stk_mem[stk_waddr] <= stk_wdata;
        end
        r_stk_rd <= stk_mem[stk_raddr];
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    `RDMC_ASSERT(a_depth_bound, i_clk, i_rst_n, r_depth <= DEPTH_W'(NODE_COUNT), "stack depth overflow")
    `RDMC_ASSERT(a_scan_nonempty, i_clk, i_rst_n, (r_state == ST_SCAN || r_state == ST_TEST) |-> r_depth != '0, "scan on empty stack")
    `RDMC_ASSERT(a_done_clean, i_clk, i_rst_n, (o_out_valid && o_out_item.walk_done) |-> (o_out_item.wall_row == '0 && o_out_item.wall_col == '0 && o_out_item.node_row == '0 && o_out_item.node_col == '0), "done item carries coordinates")
    `RDMC_ASSERT(a_done_restart, i_clk, i_rst_n, (r_state == ST_EMIT && r_res.walk_done) |-> (r_depth == '0 && r_pend_row == '0 && r_pend_col == '0), "done without empty stack")
    `RDMC_ASSERT_ALWAYS(a_reset_clear, i_clk, !i_rst_n |=> (r_state == ST_CLEAR && !o_out_valid), "reset does not start clearing pass")

endmodule
